// ----- sv/hgpa_pkg.sv -----
// ============================================================================
// hgpa_pkg
// Shared types and constants for the HSV gain pixel adjuster.
// ============================================================================
package hgpa_pkg;

    localparam int GAIN_W = 16;
    localparam int ADDR_W = 2;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_HUE_GAIN        = 2'd0;
    localparam logic [ADDR_W-1:0] REG_SATURATION_GAIN = 2'd1;
    localparam logic [ADDR_W-1:0] REG_BRIGHTNESS_GAIN = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // Hue sectors of the back conversion.
    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;

    typedef struct packed {
        logic [GAIN_W-1:0] hue;
        logic [GAIN_W-1:0] saturation;
        logic [GAIN_W-1:0] brightness;
    } gains_t;

endpackage

// ----- sv/hgpa_front.sv -----
// ============================================================================
// hgpa_front
// Max/min search, hue numerator selection and divider operand setup.
// ============================================================================
module hgpa_front #(
    parameter int C = 16
) (
    input  logic           clk,
    input  logic [2:0]     en,
    input  logic [15:0]    red,
    input  logic [15:0]    green,
    input  logic [15:0]    blue,
    output logic [C-1:0]   sat_rem,
    output logic [C-1:0]   sat_low,
    output logic [C-1:0]   sat_div,
    output logic [C+2:0]   hue_rem,
    output logic [C+2:0]   hue_div,
    output logic           neg,
    output logic           sat_zero,
    output logic           hue_zero
);

    logic [C-1:0] r_reg, g_reg, b_reg;
    logic [C-1:0] mx_reg, d_reg;
    logic [C+2:0] num_reg;
    logic         neg1_reg;

    logic [C-1:0] sat_rem_reg, sat_low_reg, sat_div_reg;
    logic [C+2:0] hue_rem_reg, hue_div_reg;
    logic         neg2_reg, sat_zero_reg, hue_zero_reg;

    logic [C-1:0] mx_next, mn_next, d_next;
    logic [C+2:0] num_next;
    logic         neg_next;
    logic [C+2:0] r_w, g_w, b_w, d_w;

    always_comb
    begin
        mx_next = r_reg;
        mn_next = r_reg;
        if (g_reg > mx_next) mx_next = g_reg;
        if (b_reg > mx_next) mx_next = b_reg;
        if (g_reg < mn_next) mn_next = g_reg;
        if (b_reg < mn_next) mn_next = b_reg;
        d_next = mx_next - mn_next;
        r_w = (C+3)'(r_reg);
        g_w = (C+3)'(g_reg);
        b_w = (C+3)'(b_reg);
        d_w = (C+3)'(d_next);
        neg_next = 1'b0;
        if (r_reg == mx_next) begin
            if (g_reg >= b_reg) begin
                num_next = g_w - b_w;
            end else begin
                num_next = b_w - g_w;
                neg_next = 1'b1;
            end
        end else if (g_reg == mx_next) begin
            num_next = (d_w << 1) + b_w - r_w;
        end else begin
            num_next = (d_w << 2) + r_w - g_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            r_reg <= C'(red);
            g_reg <= C'(green);
            b_reg <= C'(blue);
        end
        if (en[1]) begin
            mx_reg   <= mx_next;
            d_reg    <= d_next;
            num_reg  <= num_next;
            neg1_reg <= neg_next;
        end
        if (en[2]) begin
            // d*CMAX = (d-1)*2^C + (2^C-d): high and low halves of the dividend.
            sat_rem_reg  <= (d_reg == '0) ? '0 : d_reg - C'(1);
            sat_low_reg  <= C'(0) - d_reg;
            sat_div_reg  <= mx_reg;
            hue_rem_reg  <= num_reg;
            hue_div_reg  <= ((C+3)'(d_reg) << 2) + ((C+3)'(d_reg) << 1);
            neg2_reg     <= neg1_reg;
            sat_zero_reg <= (mx_reg == '0);
            hue_zero_reg <= (d_reg == '0);
        end
    end

    assign sat_rem  = sat_rem_reg;
    assign sat_low  = sat_low_reg;
    assign sat_div  = sat_div_reg;
    assign hue_rem  = hue_rem_reg;
    assign hue_div  = hue_div_reg;
    assign neg      = neg2_reg;
    assign sat_zero = sat_zero_reg;
    assign hue_zero = hue_zero_reg;

endmodule

// ----- sv/hgpa_div.sv -----
// ============================================================================
// hgpa_div
// Two restoring dividers side by side, one quotient bit per pipeline stage.
// ============================================================================
module hgpa_div #(
    parameter int C = 16
) (
    input  logic           clk,
    input  logic [C-1:0]   en,
    input  logic [C-1:0]   sat_rem,
    input  logic [C-1:0]   sat_low,
    input  logic [C-1:0]   sat_div,
    input  logic [C+2:0]   hue_rem,
    input  logic [C+2:0]   hue_div,
    input  logic           neg,
    input  logic           sat_zero,
    input  logic           hue_zero,
    output logic [C-1:0]   sat_quo,
    output logic [C-1:0]   hue_quo,
    output logic [C-1:0]   value,
    output logic           neg_out,
    output logic           sat_zero_out,
    output logic           hue_zero_out
);

    logic [C-1:0] rs_reg [C];
    logic [C-1:0] ls_reg [C];
    logic [C-1:0] ds_reg [C];
    logic [C-1:0] qs_reg [C];
    logic [C+2:0] rh_reg [C];
    logic [C+2:0] dh_reg [C];
    logic [C-1:0] qh_reg [C];
    logic         ng_reg [C];
    logic         zs_reg [C];
    logic         zh_reg [C];

    for (genvar k = 0; k < C; k++) begin : g_stage
        logic [C-1:0] rs_in, ls_in, ds_in, qs_in, qh_in;
        logic [C+2:0] rh_in, dh_in;
        logic         ng_in, zs_in, zh_in;
        logic [C:0]   ts;
        logic [C+3:0] th;
        logic         ge_s, ge_h;

        if (k == 0) begin : g_first
            assign rs_in = sat_rem;
            assign ls_in = sat_low;
            assign ds_in = sat_div;
            assign qs_in = '0;
            assign rh_in = hue_rem;
            assign dh_in = hue_div;
            assign qh_in = '0;
            assign ng_in = neg;
            assign zs_in = sat_zero;
            assign zh_in = hue_zero;
        end else begin : g_next
            assign rs_in = rs_reg[k-1];
            assign ls_in = ls_reg[k-1];
            assign ds_in = ds_reg[k-1];
            assign qs_in = qs_reg[k-1];
            assign rh_in = rh_reg[k-1];
            assign dh_in = dh_reg[k-1];
            assign qh_in = qh_reg[k-1];
            assign ng_in = ng_reg[k-1];
            assign zs_in = zs_reg[k-1];
            assign zh_in = zh_reg[k-1];
        end

        assign ts   = {rs_in, ls_in[C-1]};
        assign th   = {rh_in, 1'b0};
        assign ge_s = (ts >= {1'b0, ds_in});
        assign ge_h = (th >= {1'b0, dh_in});

        always_ff @(posedge clk)
        begin
            if (en[k]) begin
                rs_reg[k] <= ge_s ? C'(ts - {1'b0, ds_in}) : C'(ts);
                ls_reg[k] <= ls_in << 1;
                ds_reg[k] <= ds_in;
                qs_reg[k] <= {qs_in[C-2:0], ge_s};
                rh_reg[k] <= ge_h ? (C+3)'(th - {1'b0, dh_in}) : (C+3)'(th);
                dh_reg[k] <= dh_in;
                qh_reg[k] <= {qh_in[C-2:0], ge_h};
                ng_reg[k] <= ng_in;
                zs_reg[k] <= zs_in;
                zh_reg[k] <= zh_in;
            end
        end
    end

    assign sat_quo      = qs_reg[C-1];
    assign hue_quo      = qh_reg[C-1];
    // The saturation divisor is the largest channel, which is also the value.
    assign value        = ds_reg[C-1];
    assign neg_out      = ng_reg[C-1];
    assign sat_zero_out = zs_reg[C-1];
    assign hue_zero_out = zh_reg[C-1];

endmodule

// ----- sv/hgpa_back.sv -----
// ============================================================================
// hgpa_back
// Gain scaling, clamping and HSV to RGB back conversion.
// ============================================================================
module hgpa_back #(
    parameter int C = 16,
    parameter int G = 14
) (
    input  logic             clk,
    input  logic [7:0]       en,
    input  hgpa_pkg::gains_t gains,
    input  logic [C-1:0]     sat_quo,
    input  logic [C-1:0]     hue_quo,
    input  logic [C-1:0]     value,
    input  logic             neg,
    input  logic             sat_zero,
    input  logic             hue_zero,
    output logic [C-1:0]     red,
    output logic [C-1:0]     green,
    output logic [C-1:0]     blue
);

    localparam int GW = hgpa_pkg::GAIN_W;
    localparam logic [C-1:0]    CMAX = {C{1'b1}};
    localparam logic [C:0]      TURN = (C+1)'(1) << C;
    localparam logic [C+GW:0]   LIM  = (C+GW+1)'(1) << (C + G);

    function automatic logic [C-1:0] div_cmax(input logic [2*C-1:0] x);
        logic [2*C:0] y;
        y = (2*C+1)'(x) + (2*C+1)'(x >> C) + (2*C+1)'(1);
        return y[2*C-1:C];
    endfunction

    logic [C-1:0]    ha_reg, sa_reg, va_reg;
    logic [C+GW-1:0] hp_reg, sp_reg, vp_reg;
    logic [C-1:0]    hc_reg, sc_reg, vc_reg;
    logic [2:0]      secd_reg;
    logic [C-1:0]    fd_reg, sd_reg, vd_reg;
    logic [C:0]      tfd_reg;
    logic [2:0]      sece_reg;
    logic [2*C-1:0]  sf_reg, pp_reg;
    logic [2*C:0]    stf_reg;
    logic [C-1:0]    ve_reg;
    logic [2:0]      secf_reg;
    logic [C-1:0]    qa_reg, ta_reg, pf_reg, vf_reg;
    logic [2:0]      secg_reg;
    logic [2*C-1:0]  qp_reg, tp_reg;
    logic [C-1:0]    pg_reg, vg_reg;
    logic [C-1:0]    ro_reg, go_reg, bo_reg;

    logic [C+2:0]    h6;
    logic [C-1:0]    q_w, t_w;

    assign h6  = ((C+3)'(hc_reg) << 2) + ((C+3)'(hc_reg) << 1);
    assign q_w = div_cmax(qp_reg);
    assign t_w = div_cmax(tp_reg);

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            // A negative hue wraps around by one turn.
            if (hue_zero)
                ha_reg <= '0;
            else if (neg && hue_quo != '0)
                ha_reg <= C'(TURN - (C+1)'(hue_quo));
            else
                ha_reg <= hue_quo;
            sa_reg <= sat_zero ? '0 : sat_quo;
            va_reg <= value;
        end
        if (en[1]) begin
            hp_reg <= (C+GW)'(ha_reg) * (C+GW)'(gains.hue);
            sp_reg <= (C+GW)'(sa_reg) * (C+GW)'(gains.saturation);
            vp_reg <= (C+GW)'(va_reg) * (C+GW)'(gains.brightness);
        end
        if (en[2]) begin
            // A hue that reaches a full turn is the same as hue zero.
            hc_reg <= ({1'b0, hp_reg} >= LIM) ? '0   : hp_reg[C+G-1:G];
            sc_reg <= ({1'b0, sp_reg} >= LIM) ? CMAX : sp_reg[C+G-1:G];
            vc_reg <= ({1'b0, vp_reg} >= LIM) ? CMAX : vp_reg[C+G-1:G];
        end
        if (en[3]) begin
            secd_reg <= h6[C+2:C];
            fd_reg   <= h6[C-1:0];
            tfd_reg  <= TURN - (C+1)'(h6[C-1:0]);
            sd_reg   <= sc_reg;
            vd_reg   <= vc_reg;
        end
        if (en[4]) begin
            sf_reg   <= (2*C)'(sd_reg) * (2*C)'(fd_reg);
            stf_reg  <= (2*C+1)'(sd_reg) * (2*C+1)'(tfd_reg);
            pp_reg   <= (2*C)'(vd_reg) * (2*C)'(CMAX - sd_reg);
            sece_reg <= secd_reg;
            ve_reg   <= vd_reg;
        end
        if (en[5]) begin
            qa_reg   <= CMAX - sf_reg[2*C-1:C];
            ta_reg   <= CMAX - C'(stf_reg[2*C:C]);
            pf_reg   <= div_cmax(pp_reg);
            secf_reg <= sece_reg;
            vf_reg   <= ve_reg;
        end
        if (en[6]) begin
            qp_reg   <= (2*C)'(vf_reg) * (2*C)'(qa_reg);
            tp_reg   <= (2*C)'(vf_reg) * (2*C)'(ta_reg);
            pg_reg   <= pf_reg;
            vg_reg   <= vf_reg;
            secg_reg <= secf_reg;
        end
        if (en[7]) begin
            case (secg_reg)
                hgpa_pkg::SECTOR_0: begin ro_reg <= vg_reg; go_reg <= t_w;    bo_reg <= pg_reg; end
                hgpa_pkg::SECTOR_1: begin ro_reg <= q_w;    go_reg <= vg_reg; bo_reg <= pg_reg; end
                hgpa_pkg::SECTOR_2: begin ro_reg <= pg_reg; go_reg <= vg_reg; bo_reg <= t_w;    end
                hgpa_pkg::SECTOR_3: begin ro_reg <= pg_reg; go_reg <= q_w;    bo_reg <= vg_reg; end
                hgpa_pkg::SECTOR_4: begin ro_reg <= t_w;    go_reg <= pg_reg; bo_reg <= vg_reg; end
                default:            begin ro_reg <= vg_reg; go_reg <= pg_reg; bo_reg <= q_w;    end
            endcase
        end
    end

    assign red   = ro_reg;
    assign green = go_reg;
    assign blue  = bo_reg;

endmodule

// ----- sv/hsv_gain_pixel_adjust_top.sv -----
// The pipe holds CHANNEL_BITS + 11 register stages, from the stage that accepts an input beat
// to the output register that presents its output beat.
// Throughput: one pixel per cycle; each pipeline stage holds its beat while the
// stage after it is full and cannot move on, so the stream stalls without loss.
// Most of the latency comes from the divider, which resolves one quotient bit per stage.
// Reset clears all valid bits and loads every gain with 1.0; data registers keep no reset.
// ============================================================================
// hsv_gain_pixel_adjust_top
// RGB to HSV conversion, per-component gain with clamping, and HSV to RGB.
// ============================================================================
module hsv_gain_pixel_adjust_top #(
    parameter int CHANNEL_BITS       = 16,
    parameter int GAIN_FRACTION_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // red_in[15:0], green_in[31:16], blue_in[47:32]
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // red_out[15:0], green_out[31:16], blue_out[47:32]
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [hgpa_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [hgpa_pkg::GAIN_W-1:0]   cfg_wdata
);

    localparam int C   = CHANNEL_BITS;
    // Three front stages, C divider stages, eight back conversion stages.
    localparam int NST = C + 11;

    hgpa_pkg::gains_t gains_reg;
    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   en;

    // Configuration registers. Writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gains_reg.hue        <= hgpa_pkg::GAIN_RESET;
            gains_reg.saturation <= hgpa_pkg::GAIN_RESET;
            gains_reg.brightness <= hgpa_pkg::GAIN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                hgpa_pkg::REG_HUE_GAIN:        gains_reg.hue        <= cfg_wdata;
                hgpa_pkg::REG_SATURATION_GAIN: gains_reg.saturation <= cfg_wdata;
                hgpa_pkg::REG_BRIGHTNESS_GAIN: gains_reg.brightness <= cfg_wdata;
                default:                       gains_reg            <= gains_reg;
            endcase
        end
    end

    // A stage may load when it is empty or when its own beat moves on in the
    // same cycle. The last stage is the output register.
    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NST-1];

    logic [C-1:0] f_sat_rem, f_sat_low, f_sat_div;
    logic [C+2:0] f_hue_rem, f_hue_div;
    logic         f_neg, f_sat_zero, f_hue_zero;

    hgpa_front #(.C(C)) u_front (
        .clk      (clk),
        .en       (en[2:0]),
        .red      (s_axis_tdata[15:0]),
        .green    (s_axis_tdata[31:16]),
        .blue     (s_axis_tdata[47:32]),
        .sat_rem  (f_sat_rem),
        .sat_low  (f_sat_low),
        .sat_div  (f_sat_div),
        .hue_rem  (f_hue_rem),
        .hue_div  (f_hue_div),
        .neg      (f_neg),
        .sat_zero (f_sat_zero),
        .hue_zero (f_hue_zero)
    );

    logic [C-1:0] d_sat_quo, d_hue_quo, d_value;
    logic         d_neg, d_sat_zero, d_hue_zero;

    hgpa_div #(.C(C)) u_div (
        .clk          (clk),
        .en           (en[C+2:3]),
        .sat_rem      (f_sat_rem),
        .sat_low      (f_sat_low),
        .sat_div      (f_sat_div),
        .hue_rem      (f_hue_rem),
        .hue_div      (f_hue_div),
        .neg          (f_neg),
        .sat_zero     (f_sat_zero),
        .hue_zero     (f_hue_zero),
        .sat_quo      (d_sat_quo),
        .hue_quo      (d_hue_quo),
        .value        (d_value),
        .neg_out      (d_neg),
        .sat_zero_out (d_sat_zero),
        .hue_zero_out (d_hue_zero)
    );

    logic [C-1:0] b_red, b_green, b_blue;

    hgpa_back #(.C(C), .G(GAIN_FRACTION_BITS)) u_back (
        .clk      (clk),
        .en       (en[NST-1:C+3]),
        .gains    (gains_reg),
        .sat_quo  (d_sat_quo),
        .hue_quo  (d_hue_quo),
        .value    (d_value),
        .neg      (d_neg),
        .sat_zero (d_sat_zero),
        .hue_zero (d_hue_zero),
        .red      (b_red),
        .green    (b_green),
        .blue     (b_blue)
    );

    assign m_axis_tdata = {16'(b_blue), 16'(b_green), 16'(b_red)};

    // An accepted beat always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    // Input back-pressure only happens when every stage holds a beat.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A stalled output beat keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output beat changed");

endmodule

// ----- sim/hsv_gain_pixel_adjust_top_test.sv -----
// ============================================================================
// hsv_gain_pixel_adjust_top_test
// Self-checking bench for the HSV gain pixel adjuster. Pixels are streamed in
// under random idling and output stalls. An independent fixed-point model of
// the HSV round trip predicts each output beat, and a scoreboard compares the
// output beats in order. Gains are changed between phases while idle.
// ============================================================================
module hsv_gain_pixel_adjust_top_test;

    localparam int CB = 16;
    localparam int GB = 14;
    localparam longint unsigned CMAX = (64'd1 << CB) - 1;
    localparam longint unsigned TURN = 64'd1 << CB;
    localparam int LATENCY = CB + 11;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } pixel_t;

    // Scoreboard: holds the predicted pixels in arrival order.
    class pixel_scoreboard;
        pixel_t expected_q[$];
        int errors;
        int checked;

        function void note_input(pixel_t px);
            expected_q.push_back(px);
        endfunction

        task report(string what, pixel_t got, pixel_t want);
            errors++;
            $display("MISMATCH %s: got r=%h g=%h b=%h, want r=%h g=%h b=%h", what,
                     got.red, got.green, got.blue, want.red, want.green, want.blue);
        endtask

        task check_result(pixel_t got);
            pixel_t want;
            if (expected_q.size() == 0) begin
                report("unexpected beat", got, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.red != want.red) report("red", got, want);
            if (got.green != want.green) report("green", got, want);
            if (got.blue != want.blue) report("blue", got, want);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        cfg_we;
    logic [hgpa_pkg::ADDR_W-1:0] cfg_addr;
    logic [hgpa_pkg::GAIN_W-1:0] cfg_wdata;

    hsv_gain_pixel_adjust_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    pixel_scoreboard sb;
    hgpa_pkg::gains_t gains;
    // Idle percentage of each side; zero gives a stretch with no idling.
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int sent;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint unsigned gain_clamp(longint unsigned x, logic [15:0] g,
                                                   longint unsigned lim);
        longint unsigned y;
        y = (x * g) >> GB;
        return (y > lim) ? lim : y;
    endfunction

    // Fixed-point HSV round trip with the configured gains applied.
    function automatic pixel_t adjust_pixel(pixel_t px, hgpa_pkg::gains_t gn);
        longint unsigned r, g, b, mx, mn, d, s, v, h, num, h6, f, p, q, t;
        bit neg;
        pixel_t o;
        r = px.red; g = px.green; b = px.blue;
        mx = r; mn = r; s = 0; h = 0; neg = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        v = mx;
        d = mx - mn;
        if (mx != 0) begin
            s = (d * CMAX) / mx;
            if (d != 0) begin
                if (r == mx) begin
                    if (g >= b) num = g - b;
                    else begin
                        num = b - g;
                        neg = 1;
                    end
                end else if (g == mx) num = 2 * d + b - r;
                else num = 4 * d + r - g;
                h = (num * TURN) / (6 * d);
                // A negative hue wraps around by one turn.
                if (neg) h = (h == 0) ? 0 : TURN - h;
            end
        end
        h = gain_clamp(h, gn.hue, TURN);
        s = gain_clamp(s, gn.saturation, CMAX);
        v = gain_clamp(v, gn.brightness, CMAX);
        if (h >= TURN) h = 0;
        h6 = h * 6;
        f = h6 & (TURN - 1);
        p = v * (CMAX - s) / CMAX;
        q = v * (CMAX - ((s * f) >> CB)) / CMAX;
        t = v * (CMAX - ((s * (TURN - f)) >> CB)) / CMAX;
        case (h6 >> CB)
            hgpa_pkg::SECTOR_0: begin o.red = v; o.green = t; o.blue = p; end
            hgpa_pkg::SECTOR_1: begin o.red = q; o.green = v; o.blue = p; end
            hgpa_pkg::SECTOR_2: begin o.red = p; o.green = v; o.blue = t; end
            hgpa_pkg::SECTOR_3: begin o.red = p; o.green = q; o.blue = v; end
            hgpa_pkg::SECTOR_4: begin o.red = t; o.green = p; o.blue = v; end
            default:            begin o.red = v; o.green = p; o.blue = q; end
        endcase
        return o;
    endfunction

    // Output side: checks each accepted beat, with random stalls plus one long hold-off when requested.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(pixel_t'(m_axis_tdata));
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_gain(logic [hgpa_pkg::ADDR_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            hgpa_pkg::REG_HUE_GAIN:        gains.hue = val;
            hgpa_pkg::REG_SATURATION_GAIN: gains.saturation = val;
            hgpa_pkg::REG_BRIGHTNESS_GAIN: gains.brightness = val;
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [15:0] hg, logic [15:0] sg, logic [15:0] bg);
        write_gain(hgpa_pkg::REG_HUE_GAIN, hg);
        write_gain(hgpa_pkg::REG_SATURATION_GAIN, sg);
        write_gain(hgpa_pkg::REG_BRIGHTNESS_GAIN, bg);
    endtask

    // Sends one pixel, with a random idle gap first; valid stays up until taken.
    // Valid is left high after the accepting edge so the next pixel can follow
    // with no gap; drain drops it.
    task automatic send_pixel(pixel_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(adjust_pixel(px, gains));
        sent++;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Pixel with random color; some with ties between channels.
    function automatic pixel_t rand_pixel();
        pixel_t px;
        px.red = rand_chan();
        px.green = rand_chan();
        px.blue = rand_chan();
        case ($urandom_range(7))
            0: px.green = px.red;
            1: px.blue = px.red;
            2: px.blue = px.green;
            3: begin px.green = px.red; px.blue = px.red; end
            default: ;
        endcase
        return px;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    initial
    begin
        sb = new();
        gains = '{hue: hgpa_pkg::GAIN_RESET, saturation: hgpa_pkg::GAIN_RESET,
                  brightness: hgpa_pkg::GAIN_RESET};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        send_idle_pct = 31;
        recv_idle_pct = 31;
        hold_off_cycles = 0;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pixels at reset gains: black, white, primaries, secondaries,
        // a red maximum with blue above green (negative hue), and channel ties.
        send_pixel('{blue: 16'h0000, green: 16'h0000, red: 16'h0000});
        send_pixel('{blue: 16'hFFFF, green: 16'hFFFF, red: 16'hFFFF});
        send_pixel('{blue: 16'h0000, green: 16'h0000, red: 16'hFFFF});
        send_pixel('{blue: 16'h0000, green: 16'hFFFF, red: 16'h0000});
        send_pixel('{blue: 16'hFFFF, green: 16'h0000, red: 16'h0000});
        send_pixel('{blue: 16'h0000, green: 16'hFFFF, red: 16'hFFFF});
        send_pixel('{blue: 16'hFFFF, green: 16'hFFFF, red: 16'h0000});
        send_pixel('{blue: 16'hFFFF, green: 16'h0000, red: 16'hFFFF});
        send_pixel('{blue: 16'h8000, green: 16'h1000, red: 16'hF000});
        send_pixel('{blue: 16'h0001, green: 16'h0000, red: 16'hFFFF});
        send_pixel('{blue: 16'h5555, green: 16'hAAAA, red: 16'hAAAA});
        send_pixel('{blue: 16'h0001, green: 16'h0001, red: 16'h0002});
        send_pixel('{blue: 16'h1234, green: 16'hFEDC, red: 16'h8001});
        drain();

        // Hue gain at maximum pushes the hue past a full turn; all gains zero
        // and all at maximum cover the clamps; an unused index must be ignored.
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= hgpa_pkg::ADDR_W'(3);
        cfg_wdata <= 16'h0000;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_pixel('{blue: 16'h0000, green: 16'h4000, red: 16'hFFFF});
        send_pixel('{blue: 16'hFFFF, green: 16'h0000, red: 16'hF000});
        send_pixel('{blue: 16'h2000, green: 16'h8000, red: 16'h4000});
        random_phase(150);
        drain();
        set_gains(16'h0000, 16'h0000, 16'h0000);
        send_pixel('{blue: 16'h2000, green: 16'h8000, red: 16'hFFFF});
        random_phase(100);
        drain();

        // Long output hold-off while pixels keep coming, so the pipe backs up.
        set_gains(hgpa_pkg::GAIN_RESET, hgpa_pkg::GAIN_RESET, hgpa_pkg::GAIN_RESET);
        hold_off_cycles = 300;
        random_phase(250);
        drain();

        // A stretch with no idling on either side.
        set_gains(16'h2000, 16'h6000, 16'h5000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(200);
        drain();

        send_idle_pct = 31;
        recv_idle_pct = 31;
        repeat (4)
        begin
            set_gains(16'($urandom), 16'($urandom), 16'($urandom));
            random_phase(100);
            drain();
        end

        $display("Covered %0d pixels, %0d output beats checked, under gains from zero to",
                 sent, sb.checked);
        $display("full scale, with random idling, stalls and one long output hold-off.");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("Timeout");
        $display("Some tests failed");
        $finish;
    end
endmodule

// ----- hsv_gain_pixel_adjust_top.f -----
sv/hgpa_pkg.sv
sv/hgpa_front.sv
sv/hgpa_div.sv
sv/hgpa_back.sv
sv/hsv_gain_pixel_adjust_top.sv
sim/hsv_gain_pixel_adjust_top_test.sv
